>>> rtl/core/fuzzy_subsequence_run_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// fuzzy subsequence run matcher assertion macros
// shared concurrent check helpers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_RUN_MATCHER_TOP_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_RUN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define FSRM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsrm check failed");

// next-cycle implication
`define FSRM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsrm check failed");

`endif

>>> rtl/core/fsrm_pkg.sv
// ----------------------------------------------------------------------------
// fsrm_pkg
// types, sizes and helpers shared by the fuzzy subsequence run matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsrm_pkg;

	localparam int MAX_NEEDLE_LEN = 32;
	localparam int MAX_RUNS       = 16;
	localparam int MAX_ITEM_LEN   = 1024;

	localparam int NEEDLE_IDX_W = $clog2(MAX_NEEDLE_LEN);
	localparam int NEEDLE_POS_W = $clog2(MAX_NEEDLE_LEN + 1);
	localparam int LEN_W        = 6;
	localparam int MAX_RUNS_W   = 5;
	localparam int POS_W        = $clog2(MAX_ITEM_LEN + 1);
	localparam int START_W      = $clog2(MAX_ITEM_LEN);
	localparam int SCORE_W      = NEEDLE_POS_W;
	localparam int RUNS_W       = $clog2(MAX_RUNS + 1);
	localparam int RUN_IDX_W    = $clog2(MAX_RUNS);
	localparam int RAM_ADDR_W   = RUN_IDX_W + 1;
	localparam int RAM_DEPTH    = 2 * MAX_RUNS;
	localparam int CFG_ADDR_W   = 6;
	localparam int CFG_DATA_W   = 64;
	localparam int REG_IDX_W    = 3;
	localparam int NEEDLE_WORDS = 4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NEEDLE_0_7   = 3'd0,
		REG_NEEDLE_8_15  = 3'd1,
		REG_NEEDLE_16_23 = 3'd2,
		REG_NEEDLE_24_31 = 3'd3,
		REG_NEEDLE_LEN   = 3'd4,
		REG_MAX_RUNS     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] item_byte;
		logic       byte_valid;
		logic       item_end;
	} item_t;

	typedef struct packed {
		logic [9:0] run_start;
		logic [10:0] run_stop;
		logic [5:0] run_score;
		logic [4:0] run_total;
		logic       no_runs;
		logic       last_of_string;
	} result_t;

	typedef struct packed {
		logic [START_W-1:0] run_start;
		logic [POS_W-1:0]   run_stop;
		logic [SCORE_W-1:0] run_score;
	} run_t;

	localparam int RUN_W = $bits(run_t);

	typedef struct packed {
		logic [MAX_NEEDLE_LEN-1:0][7:0] needle;
		logic [LEN_W-1:0]               needle_len;
		logic [MAX_RUNS_W-1:0]          run_limit;
	} cfg_t;

	// one finished string handed to the result sequencer
	typedef struct packed {
		logic              bank;
		logic [RUNS_W-1:0] count;
		logic              no_runs;
		run_t              final_run;
	} desc_t;

	typedef struct packed {
		logic                  en;
		logic [RAM_ADDR_W-1:0] addr;
		run_t                  data;
	} ram_wr_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

>>> rtl/core/fuzzy_subsequence_run_matcher_top.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_run_matcher_top
// case-blind subsequence matcher that reports the runs of needle bytes found
// ----------------------------------------------------------------------------
// A byte beat is taken every cycle while no end beat is waiting: it lands in
// an input register and the run tracker folds it into the current run in the
// following cycle. An end beat waits in that input register, holding off the
// beats behind it, until the previous string's results have all been issued
// out of the two-bank run ram, so a string's bytes overlap with the draining
// of the one before. Results leave one beat per cycle while result_ready is
// high, through a registered read of the run ram, so a string with n runs
// gives n result beats (one for a no-runs result). An end beat taken while
// the result sequencer is idle moves from the input register into the
// sequencer's descriptor registers, its read stage and the result register.
`timescale 1ns / 1ps

module fuzzy_subsequence_run_matcher_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fsrm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fsrm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fsrm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  fsrm_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output fsrm_pkg::result_t               result
);

	import fsrm_pkg::*;

	cfg_t                  cfg;
	desc_t                 desc;
	logic                  desc_valid;
	logic                  desc_ready;
	ram_wr_t               ram_wr;
	logic                  ram_re;
	logic [RAM_ADDR_W-1:0] ram_raddr;
	logic [RUN_W-1:0]      ram_rdata;

	fsrm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsrm_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.ram_wr     (ram_wr)
	);

	fsrm_ram #(
		.WIDTH (RUN_W),
		.DEPTH (RAM_DEPTH)
	) u_run_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fsrm_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (desc_valid),
		.desc_ready   (desc_ready),
		.desc         (desc),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> rtl/core/fsrm_ram.sv
// ----------------------------------------------------------------------------
// fsrm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrm_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/fsrm_cfg.sv
// ----------------------------------------------------------------------------
// fsrm_cfg
// apb register file for the needle, its length and the run limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fsrm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fsrm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fsrm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output fsrm_pkg::cfg_t                  cfg
);

	import fsrm_pkg::*;

	logic [NEEDLE_WORDS-1:0][CFG_DATA_W-1:0] needle_q;
	logic [LEN_W-1:0]                        needle_length_q;
	logic [MAX_RUNS_W-1:0]                   max_runs_q;
	logic                                    wr;
	reg_idx_t                                idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q        <= '0;
			needle_length_q <= '0;
			max_runs_q      <= MAX_RUNS_W'(MAX_RUNS);
		end else if (wr) begin
			unique case (idx)
				REG_NEEDLE_0_7:   needle_q[0] <= pwdata;
				REG_NEEDLE_8_15:  needle_q[1] <= pwdata;
				REG_NEEDLE_16_23: needle_q[2] <= pwdata;
				REG_NEEDLE_24_31: needle_q[3] <= pwdata;
				REG_NEEDLE_LEN:   needle_length_q <= pwdata[LEN_W-1:0];
				REG_MAX_RUNS:     max_runs_q <= pwdata[MAX_RUNS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NEEDLE_0_7:   prdata = needle_q[0];
			REG_NEEDLE_8_15:  prdata = needle_q[1];
			REG_NEEDLE_16_23: prdata = needle_q[2];
			REG_NEEDLE_24_31: prdata = needle_q[3];
			REG_NEEDLE_LEN:   prdata = CFG_DATA_W'(needle_length_q);
			REG_MAX_RUNS:     prdata = CFG_DATA_W'(max_runs_q);
			default:          prdata = '0;
		endcase
	end

	// lengths above the hardware limits clamp to them
	always_comb begin
		cfg.needle     = needle_q;
		cfg.needle_len = (needle_length_q > LEN_W'(MAX_NEEDLE_LEN)) ?
			LEN_W'(MAX_NEEDLE_LEN) : needle_length_q;
		cfg.run_limit  = (max_runs_q > MAX_RUNS_W'(MAX_RUNS)) ?
			MAX_RUNS_W'(MAX_RUNS) : max_runs_q;
	end

endmodule

>>> rtl/core/fsrm_match.sv
// ----------------------------------------------------------------------------
// fsrm_match
// input register and per-byte run tracker; closed runs go to the run ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrm_match (
	input  logic              clk,
	input  logic              arst_n,
	input  fsrm_pkg::cfg_t    cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  fsrm_pkg::item_t   item,
	output logic              desc_valid,
	input  logic              desc_ready,
	output fsrm_pkg::desc_t   desc,
	output fsrm_pkg::ram_wr_t ram_wr
);

	import fsrm_pkg::*;

	logic                    in_valid_s1;
	item_t                   in_s1;

	logic [NEEDLE_POS_W-1:0] needle_pos_q;
	logic [POS_W-1:0]        item_pos_q;
	logic [RUNS_W-1:0]       runs_held_q;
	logic                    stopped_q;
	logic                    bank_q;
	run_t                    cur_q;

	logic                    fire;
	logic                    in_range;
	logic                    hit;
	logic                    extend;
	logic                    full;
	logic                    open;
	logic [7:0]              needle_byte;
	logic [NEEDLE_POS_W-1:0] needle_pos_n;
	logic [POS_W-1:0]        item_pos_n;
	logic [RUNS_W-1:0]       runs_n;
	logic [RUNS_W-1:0]       last_idx;
	logic                    stopped_n;
	run_t                    cur_n;

	assign fire       = in_valid_s1 && (!in_s1.item_end || desc_ready);
	assign item_ready = !in_valid_s1 || fire;
	assign desc_valid = in_valid_s1 && in_s1.item_end;

	assign needle_byte = cfg.needle[needle_pos_q[NEEDLE_IDX_W-1:0]];
	assign in_range    = item_pos_q < POS_W'(MAX_ITEM_LEN);
	assign hit = in_s1.byte_valid && in_range && !stopped_q &&
		(needle_pos_q < cfg.needle_len) &&
		(fold_case(needle_byte) == fold_case(in_s1.item_byte));
	// a match right after the current run's last byte extends it
	assign extend   = hit && (runs_held_q != '0) && (cur_q.run_stop == item_pos_q);
	assign full     = hit && !extend && (runs_held_q >= cfg.run_limit);
	assign open     = hit && !extend && !full;
	assign last_idx = runs_held_q - RUNS_W'(1);

	always_comb begin
		needle_pos_n = needle_pos_q + NEEDLE_POS_W'(extend || open);
		item_pos_n   = item_pos_q + POS_W'(in_s1.byte_valid && in_range);
		runs_n       = runs_held_q + RUNS_W'(open);
		stopped_n    = stopped_q | full;
		cur_n        = cur_q;
		if (extend) begin
			cur_n.run_stop  = item_pos_q + POS_W'(1);
			cur_n.run_score = cur_q.run_score + SCORE_W'(1);
		end else if (open) begin
			cur_n.run_start = item_pos_q[START_W-1:0];
			cur_n.run_stop  = item_pos_q + POS_W'(1);
			cur_n.run_score = SCORE_W'(1);
		end
	end

	always_comb begin
		ram_wr.en   = fire && open && (runs_held_q != '0);
		ram_wr.addr = {bank_q, last_idx[RUN_IDX_W-1:0]};
		ram_wr.data = cur_q;
	end

	always_comb begin
		desc.bank      = bank_q;
		desc.count     = runs_n;
		desc.no_runs   = !((stopped_n || (needle_pos_n == cfg.needle_len)) &&
			(runs_n != '0));
		desc.final_run = cur_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			needle_pos_q <= '0;
			item_pos_q   <= '0;
			runs_held_q  <= '0;
			stopped_q    <= 1'b0;
			bank_q       <= 1'b0;
		end else begin
			if (item_ready) begin
				in_valid_s1 <= item_valid;
			end
			if (fire) begin
				if (in_s1.item_end) begin
					needle_pos_q <= '0;
					item_pos_q   <= '0;
					runs_held_q  <= '0;
					stopped_q    <= 1'b0;
					bank_q       <= !bank_q;
				end else begin
					needle_pos_q <= needle_pos_n;
					item_pos_q   <= item_pos_n;
					runs_held_q  <= runs_n;
					stopped_q    <= stopped_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready) begin
			in_s1 <= item;
		end
		if (fire) begin
			cur_q <= cur_n;
		end
	end

endmodule

>>> rtl/core/fsrm_drain.sv
// ----------------------------------------------------------------------------
// fsrm_drain
// result sequencer: walks a finished string's runs out of the run ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fuzzy_subsequence_run_matcher_top_defines.svh"

module fsrm_drain (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            desc_valid,
	output logic                            desc_ready,
	input  fsrm_pkg::desc_t                 desc,
	output logic                            ram_re,
	output logic [fsrm_pkg::RAM_ADDR_W-1:0] ram_raddr,
	input  logic [fsrm_pkg::RUN_W-1:0]      ram_rdata,
	output logic                            result_valid,
	input  logic                            result_ready,
	output fsrm_pkg::result_t               result
);

	import fsrm_pkg::*;

	logic              active_q;
	logic              bank_q;
	logic              no_runs_q;
	logic [RUNS_W-1:0] count_q;
	logic [RUNS_W-1:0] idx_q;
	run_t              final_q;

	logic              valid_s1;
	logic              from_ram_s1;
	run_t              run_s1;
	logic [RUNS_W-1:0] total_s1;
	logic              no_runs_s1;
	logic              last_s1;

	logic              result_valid_q;
	result_t           result_q;

	logic              move;
	logic              issue;
	logic              more_ram;
	logic              issue_last;
	logic              load;
	run_t              run_sel;

	assign load       = desc_valid && !active_q;
	assign desc_ready = !active_q;
	assign move       = valid_s1 && (!result_valid_q || result_ready);
	assign issue      = active_q && (!valid_s1 || move);
	// every run but the last sits in the ram, the last one in final_q
	assign more_ram   = !no_runs_q && ((idx_q + RUNS_W'(1)) != count_q);
	assign ram_re     = issue && more_ram;
	assign ram_raddr  = {bank_q, idx_q[RUN_IDX_W-1:0]};
	assign issue_last = issue && !more_ram;
	assign run_sel    = from_ram_s1 ? run_t'(ram_rdata) : run_s1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			valid_s1       <= 1'b0;
			from_ram_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
			end else if (issue_last) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				valid_s1    <= 1'b1;
				from_ram_s1 <= more_ram;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_q    <= desc.bank;
			no_runs_q <= desc.no_runs;
			count_q   <= desc.count;
			final_q   <= desc.final_run;
			idx_q     <= '0;
		end else if (ram_re) begin
			idx_q <= idx_q + RUNS_W'(1);
		end
		if (issue) begin
			last_s1    <= !more_ram;
			no_runs_s1 <= no_runs_q;
			total_s1   <= no_runs_q ? '0 : count_q;
			run_s1     <= no_runs_q ? '0 : final_q;
		end
		if (move) begin
			result_q.run_start      <= 10'(run_sel.run_start);
			result_q.run_stop       <= 11'(run_sel.run_stop);
			result_q.run_score      <= 6'(run_sel.run_score);
			result_q.run_total      <= 5'(total_s1);
			result_q.no_runs        <= no_runs_s1;
			result_q.last_of_string <= last_s1;
		end
	end

	`FSRM_ASSERT_IMP(a_ram_read_in_range, ram_re, (idx_q + RUNS_W'(1)) < count_q)
	`FSRM_ASSERT_IMP(a_no_runs_single, valid_s1 && no_runs_s1, last_s1 && (total_s1 == '0))
	`FSRM_ASSERT_NXT(a_last_beat_ends_string, issue_last, !active_q)

endmodule
